// ===== rtl/tprs_pkg.sv =====
// Shared types, widths and codes for the tabulated density rejection sampler.
`default_nettype none
package tprs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int QUO_W   = DATA_W + FRAC_W;
    localparam int SLOPE_W = QUO_W + 1;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam int MUL_A_W = SLOPE_W + 1;
    localparam int MUL_B_W = DATA_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CURVE_W = PROD_W + 1;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_PROPOSE = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FEW_POINTS   = 2'd1,
        ST_TABLE_FULL   = 2'd2,
        ST_ZERO_SPACING = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SLOPE_WR,
        S_MUL_Y,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_CURVE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    load_begin;
        logic    div_step;
        logic    slope_wr;
        logic    mul_x;
        logic    mul_y;
        logic    scan_init;
        logic    mem_rd;
        logic    scan_dec;
        logic    curve_mul;
        logic    curve_done;
        logic    st_load;
        t_status st;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    few;
        logic    spacing_zero;
        logic    count_zero;
        logic    new_spacing_zero;
        logic    div_last;
        logic    scan_more;
        logic    out_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/tprs_ctrl.sv =====
// Controller state machine: sequences clear, load, propose and no-op words.
`default_nettype none
module tprs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tprs_pkg::t_stat i_stat,
    output tprs_pkg::t_cmd      o_cmd
);
    import tprs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // hold off input while reset is applied
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.st_load = 1'b1;
                o_cmd.st      = ST_OK;
                n_state       = S_FINISH;
                case (i_stat.action)
                    ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    ACT_LOAD: begin
                        if (i_stat.full) begin
                            o_cmd.st = ST_TABLE_FULL;
                        end else begin
                            o_cmd.load_begin = 1'b1;
                            if (i_stat.count_zero) begin
                                n_state = S_FINISH;
                            end else if (i_stat.new_spacing_zero) begin
                                // store a flat segment, skip the divider
                                o_cmd.st = ST_ZERO_SPACING;
                                n_state  = S_SLOPE_WR;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                    end
                    ACT_PROPOSE: begin
                        if (i_stat.few) begin
                            o_cmd.st = ST_FEW_POINTS;
                        end else if (i_stat.spacing_zero) begin
                            o_cmd.st = ST_ZERO_SPACING;
                        end else begin
                            o_cmd.mul_x = 1'b1;
                            n_state     = S_MUL_Y;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SLOPE_WR;
                end
            end
            S_SLOPE_WR: begin
                o_cmd.slope_wr = 1'b1;
                n_state        = S_FINISH;
            end
            S_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_dec = 1'b1;
                    n_state        = S_SCAN_RD;
                end else begin
                    o_cmd.curve_mul = 1'b1;
                    n_state         = S_CURVE;
                end
            end
            S_CURVE: begin
                o_cmd.curve_done = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the word
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tprs_dp.sv =====
// Datapath: point tables, slope divider, shared multiplier, scan and output register.
`default_nettype none
module tprs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tprs_pkg::t_cmd                i_cmd,
    output tprs_pkg::t_stat                    o_stat,
    input  wire logic [1:0]                    i_action,
    input  wire logic [tprs_pkg::DATA_W-1:0]   i_point_x,
    input  wire logic [tprs_pkg::DATA_W-1:0]   i_point_y,
    input  wire logic [tprs_pkg::DATA_W-1:0]   i_rand_x,
    input  wire logic [tprs_pkg::DATA_W-1:0]   i_rand_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [tprs_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import tprs_pkg::*;

    // point tables
    logic [DATA_W-1:0]  mem_x [MAX_POINTS];
    logic [DATA_W-1:0]  mem_y [MAX_POINTS];
    logic [SLOPE_W-1:0] mem_s [MAX_POINTS];

    // captured word
    t_action           r_act;
    logic [DATA_W-1:0] r_px, r_py, r_rx, r_ry;

    // table state
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_peak, r_spacing, r_x0, r_xlast, r_ylast;
    logic [ADDR_W-1:0] r_saddr;

    // divider
    logic [DATA_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_dvd, r_quo;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;

    // proposal
    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_xc, r_yc;
    logic [ADDR_W-1:0]        r_j;
    logic [DATA_W-1:0]        r_rd_x, r_rd_y;
    logic [SLOPE_W-1:0]       r_rd_s;

    // result
    logic              r_acc;
    logic [DATA_W-1:0] r_val;
    t_status           r_st;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [DATA_W-1:0]         w_new_spacing;
    logic [DATA_W:0]           w_diff, w_diff_n;
    logic [DATA_W-1:0]         w_mag;
    logic [DATA_W:0]           w_rem_sh;
    logic                      w_ge;
    logic [SLOPE_W-1:0]        w_slope_mag, w_slope;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [MUL_B_W-1:0] w_delta;
    logic signed [PROD_W-1:0]  w_shift;
    logic signed [CURVE_W-1:0] w_curve, w_ycand;

    assign w_new_spacing = (r_count == CNT_W'(1)) ? (r_px - r_x0) : r_spacing;
    assign w_diff        = {1'b0, r_py} - {1'b0, r_ylast};
    assign w_diff_n      = ~w_diff + {{DATA_W{1'b0}}, 1'b1};
    assign w_mag         = w_diff[DATA_W] ? w_diff_n[DATA_W-1:0] : w_diff[DATA_W-1:0];

    assign w_rem_sh = {r_rem, r_dvd[QUO_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_spacing});

    assign w_slope_mag = {1'b0, r_quo};
    assign w_slope     = r_neg ? (~w_slope_mag + {{QUO_W{1'b0}}, 1'b1}) : w_slope_mag;

    assign w_delta = $signed({2'b00, r_xc}) - $signed({2'b00, r_rd_x});

    always_comb begin
        w_mul_a = $signed({{(MUL_A_W-DATA_W){1'b0}}, r_rx});
        w_mul_b = $signed({{(MUL_B_W-DATA_W){1'b0}}, r_xlast - r_x0});
        if (i_cmd.mul_y) begin
            w_mul_a = $signed({{(MUL_A_W-DATA_W){1'b0}}, r_ry});
            w_mul_b = $signed({{(MUL_B_W-DATA_W){1'b0}}, r_peak});
        end else if (i_cmd.curve_mul) begin
            w_mul_a = $signed({r_rd_s[SLOPE_W-1], r_rd_s});
            w_mul_b = w_delta;
        end
    end

    assign w_prod  = w_mul_a * w_mul_b;
    // arithmetic shift floors toward minus infinity
    assign w_shift = r_prod >>> FRAC_W;
    assign w_curve = {{(CURVE_W-PROD_W){w_shift[PROD_W-1]}}, w_shift}
                   + $signed({{(CURVE_W-DATA_W){1'b0}}, r_rd_y});
    assign w_ycand = $signed({{(CURVE_W-DATA_W){1'b0}}, r_yc});

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_begin) begin
            mem_x[r_count[ADDR_W-1:0]] <= r_px;
            mem_y[r_count[ADDR_W-1:0]] <= r_py;
        end
        if (i_cmd.slope_wr) begin
            mem_s[r_saddr] <= w_slope;
        end
        if (i_cmd.mem_rd) begin
            r_rd_x <= mem_x[r_j];
            r_rd_y <= mem_y[r_j];
            r_rd_s <= mem_s[r_j];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_peak      <= '0;
            r_spacing   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_peak    <= '0;
                r_spacing <= '0;
            end
            if (i_cmd.load_begin) begin
                r_count   <= r_count + CNT_W'(1);
                r_spacing <= w_new_spacing;
                if (r_py > r_peak) begin
                    r_peak <= r_py;
                end
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= t_action'(i_action);
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_rx  <= i_rand_x;
            r_ry  <= i_rand_y;
            r_acc <= 1'b0;
            r_val <= '0;
        end
        if (i_cmd.load_begin) begin
            if (r_count == '0) begin
                r_x0 <= r_px;
            end
            r_xlast <= r_px;
            r_ylast <= r_py;
            r_saddr <= ADDR_W'(r_count - CNT_W'(1));
            r_rem   <= '0;
            r_dvd   <= {w_mag, {FRAC_W{1'b0}}};
            r_quo   <= '0;
            r_neg   <= w_diff[DATA_W];
            r_step  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? DATA_W'(w_rem_sh - {1'b0, r_spacing}) : w_rem_sh[DATA_W-1:0];
            r_dvd  <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.mul_x || i_cmd.mul_y || i_cmd.curve_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_y) begin
            r_xc <= r_x0 + r_prod[2*DATA_W-1:DATA_W];
        end
        if (i_cmd.scan_init) begin
            r_yc <= r_prod[2*DATA_W-1:DATA_W];
            r_j  <= ADDR_W'(r_count - CNT_W'(2));
        end
        if (i_cmd.scan_dec) begin
            r_j <= r_j - ADDR_W'(1);
        end
        if (i_cmd.curve_done) begin
            r_acc <= (w_ycand <= w_curve);
            r_val <= r_xc;
        end
        if (i_cmd.st_load) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.res_load) begin
            r_out_data <= {{(OUT_DATA_W-DATA_W-3){1'b0}}, r_st, r_val, r_acc};
        end
    end

    assign o_stat.action           = r_act;
    assign o_stat.full             = (r_count == CNT_W'(MAX_POINTS));
    assign o_stat.few              = (r_count < CNT_W'(2));
    assign o_stat.spacing_zero     = (r_spacing == '0);
    assign o_stat.count_zero       = (r_count == '0);
    assign o_stat.new_spacing_zero = (w_new_spacing == '0);
    assign o_stat.div_last         = (r_step == STEP_W'(QUO_W - 1));
    assign o_stat.scan_more        = (r_j != '0) && (r_rd_x > r_xc);
    assign o_stat.out_busy         = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> !(r_out_valid && !i_out_ready))
        else $error("result word overwritten while pending");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_spacing != '0))
        else $error("slope division with zero spacing");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_dec |-> (r_j != '0))
        else $error("segment scan stepped below first segment");

endmodule
`default_nettype wire

// ===== rtl/tabulated_pdf_rejection_sampler_unit.sv =====
// Top level of the tabulated density rejection sampler.
`default_nettype none
// Each input word is a clear, a load of one (x, y) point, a propose or a no-op,
// chosen by tuser, and yields exactly one result word. A new word is taken
// whenever the unit is between words, even while the previous result still
// waits in the output register. A load runs the 24-step slope divider unless it
// is the first point, the table is full or the spacing is zero; a propose that is
// not refused for too few points or zero spacing scans the point tables
// downward, reading and comparing one entry at a time, over up to point count - 2
// segments. The final state of a word holds while the previous result has not
// been taken. Results are in order.
module tabulated_pdf_rejection_sampler_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, rand_x, rand_y
    input  wire logic [tprs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  wire logic [tprs_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // accepted, sample_value, status, zero padding
    output logic [tprs_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import tprs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tprs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_action    (s_axis_tuser),
        .i_point_x   (s_axis_tdata[DATA_W-1:0]),
        .i_point_y   (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_rand_x    (s_axis_tdata[3*DATA_W-1:2*DATA_W]),
        .i_rand_y    (s_axis_tdata[4*DATA_W-1:3*DATA_W]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
